### rtl/sts_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// sts_pkg
// Shared types, codes and sizes for the sorted tagged address set.
// ============================================================================
package sts_pkg;

    // Set sizes.
    localparam int CAPACITY  = 64;
    localparam int KEY_WIDTH = 12;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int IDX_W     = 6;

    // Request codes.
    typedef enum logic [2:0] {
        REQ_INSERT  = 3'd0,
        REQ_FIND_EQ = 3'd1,
        REQ_FIND_GE = 3'd2,
        REQ_QUERY   = 3'd3,
        REQ_REMOVE  = 3'd4,
        REQ_CLEAR   = 3'd5
    } req_code_t;

    // Status codes.
    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_PRESENT = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_BAD_IDX = 2'd3
    } status_code_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH,
        ST_SRCH_CMP,
        ST_POS_RD,
        ST_POS_CMP,
        ST_DECIDE,
        ST_PREV_RD,
        ST_PREV_CMP,
        ST_INS_SHIFT,
        ST_REM_SHIFT
    } state_t;

    // Request payload.
    typedef struct packed {
        logic [2:0]           req_type;
        logic [KEY_WIDTH-1:0] key;
        logic [IDX_W-1:0]     index;
    } req_t;

    // Result payload.
    typedef struct packed {
        logic             found;
        logic [CNT_W-1:0] position;
        logic             in_data;
        logic [1:0]       status;
        logic [CNT_W-1:0] entry_count;
    } rsp_t;

endpackage

### rtl/sts_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// sts_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ============================================================================
module sts_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 12
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/sorted_tagged_address_set.sv
`timescale 1ns / 1ps
// ============================================================================
// sorted_tagged_address_set
// Ascending, duplicate-free set of tagged program addresses held in one RAM.
// ============================================================================
// Usage:
// A request (req) is taken at a rising edge where start is high and busy is
// low. The result (rsp) appears for exactly one cycle with done high; the
// receiver cannot stall it, so it must take it in that cycle.
// Clear, unknown codes and removes with a bad index finish without leaving
// idle; their result shows in the cycle after they are taken. Lookups run
// a binary search, each probe a read and then a compare, at most 7 probes,
// followed by a read of the lower-bound entry and, for a data query, of the entry below it.
// An insert shifts the entries above the new key up one place and then
// writes the key; a remove shifts the entries above the removed one down
// one place. The shift moves one entry per cycle through the single RAM
// write port; a new request can be taken in the cycle in which the
// previous result is shown.
// Reset empties the set at once (fill count to zero); the RAM contents are
// not cleared, since entries at or above the fill count are never read.
// ============================================================================
module sorted_tagged_address_set
    import sts_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    output logic busy,
    output logic done,
    output rsp_t rsp
);

    state_t                state_reg, state_next;
    req_t                  req_reg, req_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      lo_reg, lo_next;
    logic [CNT_W-1:0]      hi_reg, hi_next;
    logic [ADDR_W-1:0]     mid_reg, mid_next;
    logic [CNT_W-1:0]      cur_reg, cur_next;
    logic [ADDR_W-1:0]     wa_reg, wa_next;
    logic                  pend_reg, pend_next;
    logic                  hit_reg, hit_next;
    logic                  done_reg, done_next;
    rsp_t                  res_reg, res_next;

    logic                  mem_we, mem_re;
    logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
    logic [KEY_WIDTH-1:0]  mem_wdata, mem_rdata;

    logic [CNT_W-1:0]      mid_w;
    logic                  index_ok;
    logic                  set_full;

    // Entry storage.
    sts_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (KEY_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Shared conditions.
    assign mid_w    = CNT_W'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
    assign index_ok = {1'b0, req.index} < count_reg;
    assign set_full = count_reg >= CNT_W'(CAPACITY);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (req.req_type inside {REQ_INSERT, REQ_FIND_EQ, REQ_FIND_GE, REQ_QUERY})
                    begin
                        state_next = ST_SRCH;
                    end
                    else if (req.req_type == REQ_REMOVE && index_ok)
                    begin
                        state_next = ST_REM_SHIFT;
                    end
                end
            end
            ST_SRCH:
            begin
                state_next = (lo_reg < hi_reg) ? ST_SRCH_CMP : ST_POS_RD;
            end
            ST_SRCH_CMP:
            begin
                state_next = ST_SRCH;
            end
            ST_POS_RD:
            begin
                state_next = (lo_reg < count_reg) ? ST_POS_CMP : ST_DECIDE;
            end
            ST_POS_CMP:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                state_next = ST_IDLE;
                if (req_reg.req_type == REQ_INSERT && !hit_reg && !set_full)
                begin
                    state_next = ST_INS_SHIFT;
                end
                else if (req_reg.req_type == REQ_QUERY && !hit_reg && lo_reg != '0)
                begin
                    state_next = ST_PREV_RD;
                end
            end
            ST_PREV_RD:
            begin
                state_next = ST_PREV_CMP;
            end
            ST_PREV_CMP:
            begin
                state_next = ST_IDLE;
            end
            ST_INS_SHIFT:
            begin
                if (!pend_reg && cur_reg == lo_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_REM_SHIFT:
            begin
                if (cur_reg >= count_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, RAM control and result.
    always_comb
    begin
        req_next   = req_reg;
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        cur_next   = cur_reg;
        wa_next    = wa_reg;
        pend_next  = pend_reg;
        hit_next   = hit_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = wa_reg;
        mem_wdata  = mem_rdata;
        mem_re     = 1'b0;
        mem_raddr  = mid_w[ADDR_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next = req;
                    lo_next  = '0;
                    hi_next  = count_reg;
                    hit_next = 1'b0;
                    res_next = '0;
                    res_next.status      = STAT_OK;
                    res_next.entry_count = count_reg;
                    case (req.req_type)
                        REQ_INSERT, REQ_FIND_EQ, REQ_FIND_GE, REQ_QUERY:
                        begin
                            done_next = 1'b0;
                        end
                        REQ_REMOVE:
                        begin
                            if (index_ok)
                            begin
                                cur_next  = CNT_W'({1'b0, req.index}) + CNT_W'(1);
                                pend_next = 1'b0;
                            end
                            else
                            begin
                                done_next       = 1'b1;
                                res_next.status = STAT_BAD_IDX;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            count_next           = '0;
                            done_next            = 1'b1;
                            res_next.entry_count = '0;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            // Probe the midpoint of the open range.
            ST_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = mid_w[ADDR_W-1:0];
                    mid_next  = mid_w[ADDR_W-1:0];
                end
            end
            // Narrow the range from the probed entry.
            ST_SRCH_CMP:
            begin
                if (mem_rdata < req_reg.key)
                begin
                    lo_next = CNT_W'({1'b0, mid_reg}) + CNT_W'(1);
                end
                else
                begin
                    hi_next = CNT_W'({1'b0, mid_reg});
                end
            end
            // Fetch the lower-bound entry when it exists.
            ST_POS_RD:
            begin
                if (lo_reg < count_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = lo_reg[ADDR_W-1:0];
                end
            end
            ST_POS_CMP:
            begin
                hit_next = (mem_rdata == req_reg.key);
            end
            // Finish lookups, or start an insert shift or a neighbor read.
            ST_DECIDE:
            begin
                res_next             = '0;
                res_next.found       = hit_reg;
                res_next.position    = lo_reg;
                res_next.status      = STAT_OK;
                res_next.entry_count = count_reg;
                if (req_reg.req_type == REQ_INSERT)
                begin
                    if (hit_reg)
                    begin
                        done_next       = 1'b1;
                        res_next.status = STAT_PRESENT;
                    end
                    else if (set_full)
                    begin
                        done_next       = 1'b1;
                        res_next.status = STAT_FULL;
                    end
                    else
                    begin
                        cur_next  = count_reg;
                        pend_next = 1'b0;
                    end
                end
                else if (!(req_reg.req_type == REQ_QUERY && !hit_reg && lo_reg != '0))
                begin
                    done_next = 1'b1;
                end
            end
            ST_PREV_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(lo_reg - CNT_W'(1));
            end
            // The key is inside a data section when the entry below is a jump point.
            ST_PREV_CMP:
            begin
                done_next        = 1'b1;
                res_next.in_data = mem_rdata[0];
            end
            // Move entries up one place, reading ahead of the write.
            ST_INS_SHIFT:
            begin
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wa_reg;
                    mem_wdata = mem_rdata;
                end
                if (cur_reg > lo_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ADDR_W'(cur_reg - CNT_W'(1));
                    wa_next   = cur_reg[ADDR_W-1:0];
                    cur_next  = cur_reg - CNT_W'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        mem_we               = 1'b1;
                        mem_waddr            = lo_reg[ADDR_W-1:0];
                        mem_wdata            = req_reg.key;
                        count_next           = count_reg + CNT_W'(1);
                        done_next            = 1'b1;
                        res_next.entry_count = count_reg + CNT_W'(1);
                    end
                end
            end
            // Move entries down one place over the removed one.
            ST_REM_SHIFT:
            begin
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wa_reg;
                    mem_wdata = mem_rdata;
                end
                if (cur_reg < count_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = cur_reg[ADDR_W-1:0];
                    wa_next   = ADDR_W'(cur_reg - CNT_W'(1));
                    cur_next  = cur_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next            = 1'b0;
                    count_next           = count_reg - CNT_W'(1);
                    done_next            = 1'b1;
                    res_next.entry_count = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        cur_reg <= cur_next;
        wa_reg  <= wa_next;
        hit_reg <= hit_next;
        res_reg <= res_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = res_reg;

    // The fill count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    // The RAM is written only while entries are being shifted.
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_INS_SHIFT || state_reg == ST_REM_SHIFT))
        else $error("RAM write outside a shift");

    // A shift never reads and writes the same entry in one cycle.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write collide on one entry");

    // A result is shown only when the controller is back at rest.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("result shown while busy");

    // A key inside a data section is never a stored entry.
    a_data_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && res_reg.in_data) |-> !res_reg.found)
        else $error("data section flag on a stored key");

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the sorted tagged address set.
// ============================================================================
// A queue of set requests is filled by the stimulus process and drained by
// a clocked driver. At each accepted request the bench updates its own copy
// of the sorted set and queues the answer it expects. The monitor compares
// every strobed result, field by field, with the oldest queued answer.
// The run has a short directed part, then random traffic in several pacing
// phases. The random traffic fills and empties the set, hits duplicates,
// jump/return neighbors, data sections, full-set refusals and bad removes.
// ============================================================================
module tb_top
    import sts_pkg::*;
();

    // Request codes that the block must treat as no-ops.
    localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
    localparam logic [2:0] REQ_UNUSED_7 = 3'd7;

    localparam int CLK_HALF       = 10;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 120;
    localparam int MAX_REPORTS    = 200;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req   = '0;
    logic busy;
    logic done;
    rsp_t rsp;

    // Bench copy of the set contents.
    logic [KEY_WIDTH-1:0] set_keys [CAPACITY];
    int                   set_size = 0;

    req_t ops_to_issue [$];
    rsp_t set_answers_due [$];
    logic [KEY_WIDTH-1:0] key_pool [$];

    int send_idle_pct   = 0;
    int ops_issued      = 0;
    int answers_checked = 0;
    int mismatch_count  = 0;
    int full_refusals   = 0;
    int data_hits       = 0;
    int bad_removes     = 0;
    int quiet_cycles    = 0;

    sorted_tagged_address_set dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    // Clock.
    always #CLK_HALF clk = ~clk;

    // Apply one request to the bench copy of the set and return its answer.
    function automatic rsp_t apply_set_op(req_t op);
        rsp_t ans;
        int   lb;
        logic hit;
        ans = '0;
        lb  = set_size;
        for (int i = set_size - 1; i >= 0; i--)
        begin
            if (set_keys[i] >= op.key)
                lb = i;
        end
        hit = 1'b0;
        if (lb < set_size)
            hit = (set_keys[lb] == op.key);
        case (op.req_type)
            REQ_INSERT, REQ_FIND_EQ, REQ_FIND_GE, REQ_QUERY:
            begin
                ans.found    = hit;
                ans.position = CNT_W'(lb);
                if (op.req_type == REQ_INSERT)
                begin
                    if (hit)
                        ans.status = STAT_PRESENT;
                    else if (set_size >= CAPACITY)
                        ans.status = STAT_FULL;
                    else
                    begin
                        for (int i = set_size; i > lb; i--)
                            set_keys[i] = set_keys[i - 1];
                        set_keys[lb] = op.key;
                        set_size++;
                    end
                end
                else if (op.req_type == REQ_QUERY)
                begin
                    // Inside a data section: a jump point sits just below
                    // and the key is not itself a stored entry.
                    if (lb > 0 && !hit)
                        ans.in_data = set_keys[lb - 1][0];
                end
            end
            REQ_REMOVE:
            begin
                if (int'(op.index) >= set_size)
                    ans.status = STAT_BAD_IDX;
                else
                begin
                    for (int i = op.index; i + 1 < set_size; i++)
                        set_keys[i] = set_keys[i + 1];
                    set_size--;
                end
            end
            REQ_CLEAR:
                set_size = 0;
            default:
                ;
        endcase
        ans.entry_count = CNT_W'(set_size);
        return ans;
    endfunction

    task automatic queue_op(logic [2:0] code, int key, int idx);
        req_t op;
        op.req_type = code;
        op.key      = KEY_WIDTH'(key);
        op.index    = IDX_W'(idx);
        ops_to_issue.push_back(op);
    endtask

    // Random traffic: mostly growth of the set with lookups near stored
    // keys, plus removes, clears, fill bursts and unused request codes.
    task automatic queue_random_ops(int count);
        int                   roll;
        int                   idx;
        int                   limit;
        logic [KEY_WIDTH-1:0] k;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            idx  = $urandom_range(0, 63);
            k    = KEY_WIDTH'($urandom_range(0, 4095));
            if (key_pool.size() != 0 && $urandom_range(0, 3) != 0 &&
                (roll >= 45 || $urandom_range(0, 3) == 0))
            begin
                k = key_pool[$urandom_range(0, key_pool.size() - 1)];
                k = k + KEY_WIDTH'($urandom_range(0, 2)) - KEY_WIDTH'(1);
            end
            if (roll < 45)
            begin
                queue_op(REQ_INSERT, k, idx);
                if (key_pool.size() < 256)
                    key_pool.push_back(k);
            end
            else if (roll < 52)
                queue_op(REQ_FIND_EQ, k, idx);
            else if (roll < 60)
                queue_op(REQ_FIND_GE, k, idx);
            else if (roll < 76)
                queue_op(REQ_QUERY, k, idx);
            else if (roll < 94)
            begin
                // Removes mostly aim inside the likely fill level.
                limit = key_pool.size() < CAPACITY ? key_pool.size() : CAPACITY;
                if (limit != 0 && $urandom_range(0, 3) != 0)
                    idx = $urandom_range(0, limit - 1);
                queue_op(REQ_REMOVE, k, idx);
            end
            else if (roll < 96)
            begin
                queue_op(REQ_CLEAR, k, idx);
                key_pool.delete();
            end
            else if (roll < 98)
                queue_op($urandom_range(0, 1) ? REQ_UNUSED_6 : REQ_UNUSED_7, k, idx);
            else
            begin
                // Fill burst that often runs the set into its capacity.
                limit = $urandom_range(40, 70);
                for (int b = 0; b < limit; b++)
                begin
                    k = KEY_WIDTH'($urandom_range(0, 4095));
                    queue_op(REQ_INSERT, k, $urandom_range(0, 63));
                    if (key_pool.size() < 256)
                        key_pool.push_back(k);
                end
            end
        end
    endtask

    // Hold the stimulus until every request has been answered.
    task automatic wait_until_drained();
        while (ops_to_issue.size() != 0 || start || set_answers_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d",
                         $time, name, exp_val, act_val);
        end
    endtask

    // Driver: records each accepted request and presents the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req   <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                set_answers_due.push_back(apply_set_op(req));
                ops_issued++;
            end
            if (!start || !busy)
            begin
                if (ops_to_issue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    start <= 1'b1;
                    req   <= ops_to_issue.pop_front();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: every strobed result is matched against the oldest answer.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && done)
        begin
            if (set_answers_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result with no request outstanding, got %h",
                             $time, rsp);
            end
            else
            begin
                want = set_answers_due.pop_front();
                answers_checked++;
                if (want.status == STAT_FULL)
                    full_refusals++;
                if (want.status == STAT_BAD_IDX)
                    bad_removes++;
                if (want.in_data)
                    data_hits++;
                check_field("found", want.found, rsp.found);
                check_field("position", want.position, rsp.position);
                check_field("in_data", want.in_data, rsp.in_data);
                check_field("status", want.status, rsp.status);
                check_field("entry_count", want.entry_count, rsp.entry_count);
            end
        end
    end

    // Watchdog on cycles with neither a request nor a result accepted.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty set, key extremes, jump/return neighbors,
        // data sections, duplicates, bad indexes and unused codes.
        send_idle_pct = 0;
        queue_op(REQ_FIND_EQ, 0, 0);
        queue_op(REQ_REMOVE, 4095, 0);
        queue_op(REQ_INSERT, 0, 63);
        queue_op(REQ_INSERT, 4095, 0);
        queue_op(REQ_INSERT, 4094, 0);
        queue_op(REQ_INSERT, 0, 0);
        queue_op(REQ_INSERT, 'h801, 0);
        queue_op(REQ_INSERT, 'h101, 0);
        queue_op(REQ_FIND_EQ, 4095, 0);
        queue_op(REQ_FIND_GE, 1, 0);
        queue_op(REQ_FIND_GE, 'h800, 0);
        queue_op(REQ_QUERY, 'h102, 0);
        queue_op(REQ_QUERY, 'h900, 0);
        queue_op(REQ_QUERY, 'h801, 0);
        queue_op(REQ_QUERY, 0, 0);
        queue_op(REQ_QUERY, 4095, 0);
        queue_op(REQ_QUERY, 'h050, 0);
        queue_op(REQ_REMOVE, 0, 63);
        queue_op(REQ_REMOVE, 0, 0);
        queue_op(REQ_REMOVE, 0, 3);
        queue_op(REQ_UNUSED_6, 4095, 63);
        queue_op(REQ_UNUSED_7, 0, 0);
        queue_op(REQ_FIND_EQ, 'h801, 63);
        queue_op(REQ_CLEAR, 4095, 63);
        queue_op(REQ_FIND_GE, 4095, 0);
        wait_until_drained();

        // Run the set into its capacity, then edge removes, then traffic.
        queue_op(REQ_CLEAR, 0, 0);
        for (int i = 0; i < CAPACITY + 4; i++)
            queue_op(REQ_INSERT, $urandom_range(0, 4095), 0);
        queue_op(REQ_REMOVE, 0, CAPACITY - 1);
        queue_op(REQ_REMOVE, 0, 0);
        queue_random_ops(140);
        wait_until_drained();

        // Sender idles most cycles.
        send_idle_pct = 67;
        queue_random_ops(190);
        wait_until_drained();

        // Light idling on the sender.
        send_idle_pct = 6;
        queue_random_ops(140);
        wait_until_drained();

        // Back to back again.
        send_idle_pct = 0;
        queue_random_ops(110);
        wait_until_drained();

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Ran %0d set requests over four pacing phases, %0d results checked.",
                 ops_issued, answers_checked);
        $display("Seen: %0d full-set refusals, %0d data-section hits, %0d bad removes.",
                 full_refusals, data_hits, bad_removes);
        if (mismatch_count == 0 && set_answers_due.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

### sorted_tagged_address_set.f
rtl/sts_pkg.sv
rtl/sts_ram.sv
rtl/sorted_tagged_address_set.sv
dv/tb_top.sv
